// File: src/hrps_pkg.sv
`timescale 1ns / 1ps
// shared constants, opcode type and angle table for the position stepper
package hrps_pkg;

  // field widths of the stream payload
  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int STEP_W  = 16;
  localparam int OP_W    = 3;

  localparam int IN_FIELDS_W  = 3 * POS_W + 2 * ANG_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * POS_W + 2 * ANG_W + 3;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // bit positions of the result flags in the output tdata
  localparam int OUT_MOD_BIT = 3 * POS_W + 2 * ANG_W;
  localparam int OUT_WB_BIT  = OUT_MOD_BIT + 1;
  localparam int OUT_SAT_BIT = OUT_MOD_BIT + 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10240);

  // sine and cosine format, Q1.TRIG_FB
  localparam int TRIG_FB = 15;
  localparam int TRIG_W  = TRIG_FB + 1;

  // cordic datapath, Q2.30 with headroom
  localparam int CORDIC_STEPS = 24;
  localparam int CIDX_W       = $clog2(CORDIC_STEPS);
  localparam int TURN_W       = 32;
  localparam int CORD_FB      = 30;
  localparam int CORD_W       = 34;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);

  // shared multiplier and step deltas
  localparam int TMP_W   = TRIG_W + 1;
  localparam int MUL_W   = ((STEP_W + 1) > TMP_W) ? (STEP_W + 2) : (TMP_W + 1);
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SHP_W   = PROD_W - TRIG_FB;
  localparam int DELTA_W = STEP_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_FWD   = 3'd1,
    OP_BWD   = 3'd2,
    OP_LEFT  = 3'd3,
    OP_RIGHT = 3'd4,
    OP_UP    = 3'd5,
    OP_DOWN  = 3'd6,
    OP_FLUSH = 3'd7
  } opcode_e;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TURN_W-1:0] atan_turn(input logic [CIDX_W-1:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/hrps_cordic.sv
`timescale 1ns / 1ps
// iterative cordic: sine and cosine of a binary angle, one rotation per cycle
module hrps_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [hrps_pkg::ANG_W-1:0]          angle_i,
  output logic                                done_o,
  output logic signed [hrps_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [hrps_pkg::TRIG_W-1:0]  cos_o
);
  import hrps_pkg::*;

  localparam logic [TURN_W-1:0] EIGHTH = TURN_W'(1) << (TURN_W - 3);
  localparam logic signed [CORD_W-1:0] TRIG_MAX = CORD_W'((1 << TRIG_FB) - 1);
  localparam logic signed [CORD_W-1:0] TRIG_MIN = ~TRIG_MAX;

  logic                     busy_q, fin_q, done_q;
  logic [CIDX_W-1:0]        idx_q;
  logic [1:0]               quad_q;
  logic signed [CORD_W-1:0] x_q, y_q, z_q;

  logic [TURN_W-1:0]        turn, turn_off, resid;
  logic [1:0]               quad;
  logic signed [CORD_W-1:0] xs, ys, ang, c_rot, s_rot;

  // floor shift to Q1.TRIG_FB and clip
  function automatic logic signed [TRIG_W-1:0] to_trig(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] sh;
    sh = v >>> (CORD_FB - TRIG_FB);
    if (sh > TRIG_MAX) begin
      sh = TRIG_MAX;
    end else if (sh < TRIG_MIN) begin
      sh = TRIG_MIN;
    end
    return TRIG_W'(sh);
  endfunction

  // nearest quarter turn and residual in [-1/8, 1/8) turn
  assign turn     = TURN_W'(angle_i) << (TURN_W - ANG_W);
  assign turn_off = turn + EIGHTH;
  assign quad     = turn_off[TURN_W-1 -: 2];
  assign resid    = turn - {quad, (TURN_W - 2)'(0)};

  assign xs  = x_q >>> idx_q;
  assign ys  = y_q >>> idx_q;
  assign ang = $signed({{(CORD_W - TURN_W){1'b0}}, atan_turn(idx_q)});

  // exact quarter-turn rotation of the result
  always_comb begin
    case (quad_q)
      2'd1: begin
        c_rot = -y_q;
        s_rot = x_q;
      end
      2'd2: begin
        c_rot = -x_q;
        s_rot = -y_q;
      end
      2'd3: begin
        c_rot = y_q;
        s_rot = -x_q;
      end
      default: begin
        c_rot = x_q;
        s_rot = y_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + CIDX_W'(1);
        if (idx_q == CIDX_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= CORD_W'($signed(resid));
      quad_q <= quad;
    end else if (busy_q) begin
      if (!z_q[CORD_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end
    end
    if (fin_q) begin
      sin_o <= to_trig(s_rot);
      cos_o <= to_trig(c_rot);
    end
  end

  assign done_o = done_q;

endmodule

// File: src/hrps_mul.sv
`timescale 1ns / 1ps
// shared signed multiplier with registered product and floor shift to Q.TRIG_FB
module hrps_mul (
  input  logic                               clk_i,
  input  logic signed [hrps_pkg::MUL_W-1:0]  a_i,
  input  logic signed [hrps_pkg::MUL_W-1:0]  b_i,
  output logic signed [hrps_pkg::SHP_W-1:0]  sh_o
);
  import hrps_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign sh_o = SHP_W'(prod_q >>> TRIG_FB);

endmodule

// File: src/heading_relative_position_stepper.sv
`timescale 1ns / 1ps
// heading-relative position stepper: pose state, sequencer, cordic and multiplier
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid / s_axis_tready tdata load pose, tuser opcode
// m_axis   out  m_axis_tvalid / m_axis_tready tdata pose after the item and flags
// cfg      in   cfg_we_i                      cfg_wdata_i step size, Q8.8
//
// result is registered with no cordic or multiplier work for load, up, down and flush,
// after the heading angle and two products for left and right, and after the heading
// and pitch angles and five products for forward and backward; input is ready again
// as the result is registered. the cordic runs 24 rotations per angle.
// reset clears the pose and pending flag and sets the step size to 40.0.
// input is taken only when idle; a finished item waits while the output holds.
module heading_relative_position_stepper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // load_x, load_y, load_z, load_yaw, load_pitch
  input  logic [hrps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode
  input  logic [hrps_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_x, out_y, out_z, out_yaw, out_pitch, modified, write_back, saturated, zeros
  output logic [hrps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [hrps_pkg::STEP_W-1:0]         cfg_wdata_i
);
  import hrps_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_START_H = 3'd1;
  localparam logic [2:0] ST_WAIT_H  = 3'd2;
  localparam logic [2:0] ST_START_P = 3'd3;
  localparam logic [2:0] ST_WAIT_P  = 3'd4;
  localparam logic [2:0] ST_MUL     = 3'd5;
  localparam logic [2:0] ST_MRES    = 3'd6;
  localparam logic [2:0] ST_FIN     = 3'd7;

  // multiply schedule
  localparam logic [2:0] MS_F_T0 = 3'd0;
  localparam logic [2:0] MS_F_DX = 3'd1;
  localparam logic [2:0] MS_F_T1 = 3'd2;
  localparam logic [2:0] MS_F_DZ = 3'd3;
  localparam logic [2:0] MS_F_DY = 3'd4;
  localparam logic [2:0] MS_L_DX = 3'd5;
  localparam logic [2:0] MS_L_DZ = 3'd6;

  logic [2:0]                state_q;
  logic [2:0]                mstep_q;
  opcode_e                   op_q;
  logic [STEP_W-1:0]         step_q;
  logic signed [POS_W-1:0]   ld_x_q, ld_y_q, ld_z_q;
  logic [ANG_W-1:0]          ld_yaw_q, ld_pitch_q;
  logic signed [POS_W-1:0]   pos_x_q, pos_y_q, pos_z_q;
  logic [ANG_W-1:0]          yaw_q, pitch_q;
  logic                      pend_q;
  logic signed [TRIG_W-1:0]  sy_q, cy_q, sp_q, cp_q;
  logic signed [TMP_W-1:0]   t_q;
  logic signed [DELTA_W-1:0] dx_q, dy_q, dz_q;
  logic                      m_vld_q;
  logic [OUT_TDATA_W-1:0]    out_q;

  logic                      accept, fire, cord_start, cord_done;
  logic [ANG_W-1:0]          cord_angle;
  logic signed [TRIG_W-1:0]  cord_sin, cord_cos;
  logic signed [MUL_W-1:0]   mul_a, mul_b, step_s;
  logic signed [SHP_W-1:0]   mul_sh;
  logic signed [DELTA_W-1:0] mul_d;
  logic signed [TMP_W-1:0]   neg_sp, neg_sy;
  logic [POS_W:0]            ax, ay, az;
  logic signed [POS_W-1:0]   px_d, py_d, pz_d;
  logic [ANG_W-1:0]          yaw_d, pitch_d;
  logic                      pend_d, wb_d, sat_d;
  logic                      is_move_trig, neg_fwd, neg_bwd, neg_right;

  // add and clip to the signed position range, msb is the clip flag
  function automatic logic [POS_W:0] sat_add(input logic signed [POS_W-1:0] p,
                                             input logic signed [DELTA_W-1:0] d);
    logic signed [POS_W:0] s;
    s = (POS_W + 1)'(p) + (POS_W + 1)'(d);
    if (s[POS_W] != s[POS_W-1]) begin
      return {1'b1, s[POS_W], {(POS_W - 1){~s[POS_W]}}};
    end
    return {1'b0, s[POS_W-1:0]};
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == ST_FIN) && (!m_vld_q || m_axis_tready);

  assign cord_start = (state_q == ST_START_H) || (state_q == ST_START_P);
  assign cord_angle = (state_q == ST_START_P) ? pitch_q : yaw_q;

  hrps_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (cord_angle),
    .done_o  (cord_done),
    .sin_o   (cord_sin),
    .cos_o   (cord_cos)
  );

  assign step_s = MUL_W'($signed({1'b0, step_q}));
  assign neg_sp = -TMP_W'(sp_q);
  assign neg_sy = -TMP_W'(sy_q);

  always_comb begin
    case (mstep_q)
      MS_F_T0: begin
        mul_a = MUL_W'(cp_q);
        mul_b = MUL_W'(sy_q);
      end
      MS_F_T1: begin
        mul_a = MUL_W'(cp_q);
        mul_b = MUL_W'(cy_q);
      end
      MS_F_DX, MS_F_DZ: begin
        mul_a = step_s;
        mul_b = MUL_W'(t_q);
      end
      MS_F_DY: begin
        mul_a = step_s;
        mul_b = MUL_W'(neg_sp);
      end
      MS_L_DX: begin
        mul_a = step_s;
        mul_b = MUL_W'(cy_q);
      end
      MS_L_DZ: begin
        mul_a = step_s;
        mul_b = MUL_W'(neg_sy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hrps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .sh_o  (mul_sh)
  );

  assign mul_d     = DELTA_W'(mul_sh);
  assign neg_fwd   = (op_q == OP_FWD);
  assign neg_bwd   = (op_q == OP_BWD);
  assign neg_right = (op_q == OP_RIGHT);

  assign is_move_trig = (s_axis_tuser == OP_FWD) || (s_axis_tuser == OP_BWD) ||
                        (s_axis_tuser == OP_LEFT) || (s_axis_tuser == OP_RIGHT);

  assign ax = sat_add(pos_x_q, dx_q);
  assign ay = sat_add(pos_y_q, dy_q);
  assign az = sat_add(pos_z_q, dz_q);

  always_comb begin
    px_d    = pos_x_q;
    py_d    = pos_y_q;
    pz_d    = pos_z_q;
    yaw_d   = yaw_q;
    pitch_d = pitch_q;
    pend_d  = pend_q;
    wb_d    = 1'b0;
    sat_d   = 1'b0;
    case (op_q)
      OP_LOAD: begin
        px_d    = ld_x_q;
        py_d    = ld_y_q;
        pz_d    = ld_z_q;
        yaw_d   = ld_yaw_q;
        pitch_d = ld_pitch_q;
        pend_d  = 1'b0;
      end
      OP_FLUSH: begin
        wb_d   = pend_q;
        pend_d = 1'b0;
      end
      default: begin
        px_d   = ax[POS_W-1:0];
        py_d   = ay[POS_W-1:0];
        pz_d   = az[POS_W-1:0];
        pend_d = 1'b1;
        sat_d  = ax[POS_W] | ay[POS_W] | az[POS_W];
      end
    endcase
  end

  // sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mstep_q <= MS_F_T0;
      step_q  <= STEP_RESET;
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      yaw_q   <= '0;
      pitch_q <= '0;
      pend_q  <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (fire) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= is_move_trig ? ST_START_H : ST_FIN;
          end
        end
        ST_START_H: state_q <= ST_WAIT_H;
        ST_WAIT_H: begin
          if (cord_done) begin
            if ((op_q == OP_FWD) || (op_q == OP_BWD)) begin
              state_q <= ST_START_P;
            end else begin
              mstep_q <= MS_L_DX;
              state_q <= ST_MUL;
            end
          end
        end
        ST_START_P: state_q <= ST_WAIT_P;
        ST_WAIT_P: begin
          if (cord_done) begin
            mstep_q <= MS_F_T0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_MRES;
        ST_MRES: begin
          if ((mstep_q == MS_F_DY) || (mstep_q == MS_L_DZ)) begin
            state_q <= ST_FIN;
          end else begin
            mstep_q <= mstep_q + 3'd1;
            state_q <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (fire) begin
            pos_x_q <= px_d;
            pos_y_q <= py_d;
            pos_z_q <= pz_d;
            yaw_q   <= yaw_d;
            pitch_q <= pitch_d;
            pend_q  <= pend_d;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working registers of one item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opcode_e'(s_axis_tuser);
      ld_x_q     <= s_axis_tdata[POS_W-1:0];
      ld_y_q     <= s_axis_tdata[2*POS_W-1:POS_W];
      ld_z_q     <= s_axis_tdata[3*POS_W-1:2*POS_W];
      ld_yaw_q   <= s_axis_tdata[3*POS_W+ANG_W-1:3*POS_W];
      ld_pitch_q <= s_axis_tdata[3*POS_W+2*ANG_W-1:3*POS_W+ANG_W];
      dx_q       <= '0;
      dz_q       <= '0;
      if (s_axis_tuser == OP_UP) begin
        dy_q <= DELTA_W'($signed({1'b0, step_q}));
      end else if (s_axis_tuser == OP_DOWN) begin
        dy_q <= -DELTA_W'($signed({1'b0, step_q}));
      end else begin
        dy_q <= '0;
      end
    end
    if ((state_q == ST_WAIT_H) && cord_done) begin
      sy_q <= cord_sin;
      cy_q <= cord_cos;
    end
    if ((state_q == ST_WAIT_P) && cord_done) begin
      sp_q <= cord_sin;
      cp_q <= cord_cos;
    end
    if (state_q == ST_MRES) begin
      case (mstep_q)
        MS_F_T0, MS_F_T1: t_q  <= TMP_W'(mul_sh);
        MS_F_DX:          dx_q <= neg_fwd ? -mul_d : mul_d;
        MS_F_DZ:          dz_q <= neg_fwd ? -mul_d : mul_d;
        MS_F_DY:          dy_q <= neg_bwd ? -mul_d : mul_d;
        MS_L_DX:          dx_q <= neg_right ? -mul_d : mul_d;
        MS_L_DZ:          dz_q <= neg_right ? -mul_d : mul_d;
        default:          t_q  <= t_q;
      endcase
    end
    if (fire) begin
      out_q <= OUT_TDATA_W'({sat_d, wb_d, pend_d, pitch_d, yaw_d, pz_d, py_d, px_d});
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: src/hrps_checker.sv
`timescale 1ns / 1ps
// port-level checks of the position stepper and their bind
module hrps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [hrps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import hrps_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

  logic             wb, sat, modified;
  logic [POS_W-1:0] ox, oy, oz;

  assign wb       = m_axis_tdata[OUT_WB_BIT];
  assign sat      = m_axis_tdata[OUT_SAT_BIT];
  assign modified = m_axis_tdata[OUT_MOD_BIT];
  assign ox       = m_axis_tdata[POS_W-1:0];
  assign oy       = m_axis_tdata[2*POS_W-1:POS_W];
  assign oz       = m_axis_tdata[3*POS_W-1:2*POS_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // a write-back clears the pending flag and moves nothing
  a_flush_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && wb |-> !modified && !sat)
    else $error("write-back with modified or saturated set");

  // a clipped move leaves some coordinate at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sat |-> modified && (ox == POS_MAX || ox == POS_MIN ||
      oy == POS_MAX || oy == POS_MIN || oz == POS_MAX || oz == POS_MIN))
    else $error("saturated flag without a coordinate at its limit");

endmodule

bind heading_relative_position_stepper hrps_checker u_hrps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb_heading_relative_position_stepper.sv
`timescale 1ns / 1ps
// self-checking testbench for the heading-relative position stepper
module tb_heading_relative_position_stepper;
  import hrps_pkg::*;

  typedef struct {
    opcode_e            op;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] lz;
    logic [15:0]        lyaw;
    logic [15:0]        lpitch;
  } pose_cmd_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic        modified;
    logic        write_back;
    logic        saturated;
  } pose_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [STEP_W-1:0]      cfg_wdata_i = '0;

  heading_relative_position_stepper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  pose_cmd_t    cmd_backlog[$];
  pose_result_t pose_expected[$];
  pose_cmd_t    cmd_live;
  pose_result_t pose_got;
  pose_result_t pose_want;
  bit           calm = 1'b0;
  int           n_errors = 0;
  int           n_sent = 0;
  int           n_writebacks = 0;
  int           n_clipped = 0;
  int           n_settings = 0;

  // predictor state
  longint       pos_xm, pos_ym, pos_zm;
  logic [15:0]  heading_m, pitch_m;
  bit           dirty_m;
  logic [15:0]  step_q88;

  // atan(2^-i) in 2^-32 turn units
  longint arc_lut [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint clamp_q15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clamp_pos(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // sine and cosine in q1.15 via quarter-turn reduction and 24 rotations
  function automatic void sin_cos_q15(input logic [15:0] ang, output longint s,
                                      output longint c);
    logic [31:0] a, sum, resid;
    logic [1:0]  quad;
    longint      x, y, z, t, xs, ys;
    int          i;
    a = {ang, 16'h0000};
    sum = a + 32'h2000_0000;
    quad = sum[31:30];
    resid = a - {quad, 30'h0};
    z = longint'($signed(resid));
    x = 64'sd652032874;
    y = 0;
    for (i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arc_lut[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arc_lut[i];
      end
    end
    case (quad)
      2'd1: begin
        t = x;
        x = -y;
        y = t;
      end
      2'd2: begin
        x = -x;
        y = -y;
      end
      2'd3: begin
        t = x;
        x = y;
        y = -t;
      end
      default: ;
    endcase
    c = clamp_q15(x >>> 15);
    s = clamp_q15(y >>> 15);
  endfunction

  function automatic longint by_step(input longint v);
    return (longint'(step_q88) * v) >>> 15;
  endfunction

  // advance the pose model by one item and return the pose it reports
  function automatic pose_result_t step_pose(input pose_cmd_t cmd);
    pose_result_t r;
    longint       sy, cy, sp, cp, dx, dy, dz;
    bit           sat, wb, moved;
    sat = 1'b0;
    wb = 1'b0;
    moved = 1'b1;
    dx = 0;
    dy = 0;
    dz = 0;
    sin_cos_q15(heading_m, sy, cy);
    sin_cos_q15(pitch_m, sp, cp);
    case (cmd.op)
      OP_LOAD: begin
        pos_xm = clamp_pos(longint'(cmd.lx), sat);
        pos_ym = clamp_pos(longint'(cmd.ly), sat);
        pos_zm = clamp_pos(longint'(cmd.lz), sat);
        heading_m = cmd.lyaw;
        pitch_m = cmd.lpitch;
        dirty_m = 1'b0;
        moved = 1'b0;
      end
      OP_FWD, OP_BWD: begin
        dx = -by_step((cp * sy) >>> 15);
        dy = by_step(-sp);
        dz = -by_step((cp * cy) >>> 15);
        if (cmd.op == OP_BWD) begin
          dx = -dx;
          dy = -dy;
          dz = -dz;
        end
      end
      OP_LEFT, OP_RIGHT: begin
        dx = by_step(cy);
        dz = by_step(-sy);
        if (cmd.op == OP_RIGHT) begin
          dx = -dx;
          dz = -dz;
        end
      end
      OP_UP:   dy = longint'(step_q88);
      OP_DOWN: dy = -longint'(step_q88);
      default: begin
        wb = dirty_m;
        dirty_m = 1'b0;
        moved = 1'b0;
      end
    endcase
    if (moved) begin
      pos_xm = clamp_pos(pos_xm + dx, sat);
      pos_ym = clamp_pos(pos_ym + dy, sat);
      pos_zm = clamp_pos(pos_zm + dz, sat);
      dirty_m = 1'b1;
    end
    r.x = pos_xm[31:0];
    r.y = pos_ym[31:0];
    r.z = pos_zm[31:0];
    r.yaw = heading_m;
    r.pitch = pitch_m;
    r.modified = dirty_m;
    r.write_back = wb;
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // item driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pose_expected.push_back(step_pose(cmd_live));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
          cmd_live = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cmd_live.lpitch, cmd_live.lyaw, cmd_live.lz, cmd_live.ly,
                           cmd_live.lx};
          s_axis_tuser <= cmd_live.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        pose_got.x = m_axis_tdata[31:0];
        pose_got.y = m_axis_tdata[63:32];
        pose_got.z = m_axis_tdata[95:64];
        pose_got.yaw = m_axis_tdata[111:96];
        pose_got.pitch = m_axis_tdata[127:112];
        pose_got.modified = m_axis_tdata[OUT_MOD_BIT];
        pose_got.write_back = m_axis_tdata[OUT_WB_BIT];
        pose_got.saturated = m_axis_tdata[OUT_SAT_BIT];
        if (pose_expected.size() == 0) begin
          report_mismatch("result with no item pending", pose_got.x, '0);
        end else begin
          pose_want = pose_expected.pop_front();
          n_writebacks += pose_want.write_back;
          n_clipped += pose_want.saturated;
          check_field("x", pose_got.x, pose_want.x);
          check_field("y", pose_got.y, pose_want.y);
          check_field("z", pose_got.z, pose_want.z);
          check_field("yaw", 32'(pose_got.yaw), 32'(pose_want.yaw));
          check_field("pitch", 32'(pose_got.pitch), 32'(pose_want.pitch));
          check_field("modified", 32'(pose_got.modified), 32'(pose_want.modified));
          check_field("write_back", 32'(pose_got.write_back), 32'(pose_want.write_back));
          check_field("saturated", 32'(pose_got.saturated), 32'(pose_want.saturated));
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 6);
    end
  end

  task automatic put(input opcode_e op, input logic [31:0] x, input logic [31:0] y,
                     input logic [31:0] z, input logic [15:0] yaw,
                     input logic [15:0] pitch);
    pose_cmd_t c;
    c.op = op;
    c.lx = x;
    c.ly = y;
    c.lz = z;
    c.lyaw = yaw;
    c.lpitch = pitch;
    cmd_backlog.push_back(c);
  endtask

  // payload bits of non-load items are random and must be ignored
  task automatic put_noisy(input opcode_e op);
    put(op, $urandom(), $urandom(), $urandom(), 16'($urandom()), 16'($urandom()));
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF - 32'($urandom_range(200_000));
      1:       return 32'h8000_0000 + 32'($urandom_range(200_000));
      2:       return 32'($urandom_range(131071)) - 32'd65536;
      default: return $urandom();
    endcase
  endfunction

  // octant boundaries are where the quarter-turn reduction changes
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(1) == 0) return 16'($urandom());
    return 16'($urandom_range(7) << 13) + 16'($urandom_range(2)) - 16'd1;
  endfunction

  // mostly load, a run of moves, then usually a flush; some loose items as noise
  task automatic queue_random(input int n);
    int left, run;
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        put_noisy(opcode_e'($urandom_range(7)));
        left--;
      end else begin
        put(OP_LOAD, pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle());
        run = $urandom_range(12, 2);
        repeat (run) put_noisy(opcode_e'($urandom_range(6, 1)));
        if ($urandom_range(3) != 0) put_noisy(OP_FLUSH);
        left -= run + 2;
      end
    end
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || pose_expected.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_step(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    step_q88 = v;
    n_settings++;
  endtask

  initial begin
    pos_xm = 0;
    pos_ym = 0;
    pos_zm = 0;
    heading_m = '0;
    pitch_m = '0;
    dirty_m = 1'b0;
    step_q88 = STEP_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at the reset step size
    put_noisy(OP_FLUSH);
    put_noisy(OP_FWD);
    put_noisy(OP_FLUSH);
    put(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF, 16'h0000);
    put_noisy(OP_LEFT);
    put_noisy(OP_DOWN);
    put_noisy(OP_UP);
    put(OP_LOAD, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, 16'h4000);
    put_noisy(OP_UP);
    put_noisy(OP_FWD);
    put_noisy(OP_BWD);
    put_noisy(OP_RIGHT);
    put(OP_LOAD, 32'h0, 32'h0, 32'h0, 16'h8000, 16'hC000);
    put_noisy(OP_FWD);
    put_noisy(OP_BWD);
    put_noisy(OP_LEFT);
    put_noisy(OP_RIGHT);
    put(OP_LOAD, 32'h0000_1234, 32'hFFFF_0000, 32'h0, 16'h2000, 16'h1FFF);
    put_noisy(OP_FWD);
    put(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hE000, 16'hA000);
    put_noisy(OP_BWD);
    put_noisy(OP_RIGHT);
    put_noisy(OP_FLUSH);
    put_noisy(OP_FLUSH);
    drain();

    // zero step still marks the pose dirty
    set_step(16'h0000);
    put_noisy(OP_FWD);
    put_noisy(OP_UP);
    put_noisy(OP_FLUSH);
    put_noisy(OP_FLUSH);
    queue_random(150);
    drain();

    set_step(16'hFFFF);
    queue_random(300);
    drain();

    // one phase with no random stalls on either side
    calm = 1'b1;
    set_step(16'($urandom()));
    queue_random(300);
    drain();
    calm = 1'b0;

    set_step(16'h0001);
    queue_random(150);
    drain();

    repeat (4) begin
      set_step(16'($urandom()));
      queue_random(200);
      drain();
    end

    repeat (80) @(posedge clk_i);
    $display("covered %0d items under %0d step sizes: all opcodes, octant angles,",
             n_sent, n_settings);
    $display("%0d write-backs and %0d clipping items, with random stalls on both sides",
             n_writebacks, n_clipped);
    if (n_errors == 0 && pose_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
